FILE: hw/rtl/uvs_pkg.sv
package uvs_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CapWidth    = 9;
  localparam int unsigned IndexWidth  = 8;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned ActionWidth = 2;
  localparam logic [CapWidth-1:0] CapReset = 9'd256;

  typedef enum logic [ActionWidth-1:0] {
    ACT_SEARCH = 2'd0,
    ACT_PUSH   = 2'd1,
    ACT_POP    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_OVER     = 3'd2,
    ST_UNDER    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_POP_RD,
    FSM_POP_DATA,
    FSM_DONE
  } fsm_e;

endpackage

FILE: hw/rtl/uvs_if.sv
interface uvs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         found_index;
  logic signed [31:0] popped_value;
  logic [8:0]         entry_count;

  modport source (output valid, output status, output found_index, output popped_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_index, input popped_value,
                  input entry_count, output ready);
endinterface

FILE: hw/rtl/unique_value_stack.sv
// Bounded stack of 32-bit values that refuses duplicates. One operation is in
// flight at a time and in_i.ready is low while it runs. Search and push scan
// the stored entries from the bottom through the single registered read port
// of the entry memory, one entry per cycle, and stop early on a match; a push
// onto a full stack, a search of an empty one and a clear skip the scan, and a
// pop reads the top entry in FSM_POP_RD and takes it in FSM_POP_DATA. A finished
// result sits in the output register while the next beat is accepted. The user
// must write capacity through cfg_we_i/cfg_wdata_i only while the block is idle;
// the block does not enforce this. Values above DEPTH act as DEPTH.
module unique_value_stack #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [uvs_pkg::CapWidth-1:0] cfg_wdata_i,
  uvs_in_if.sink                       in_i,
  uvs_out_if.source                    out_o
);
  import uvs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > CapWidth) ? CW : CapWidth;
  localparam logic [XW-1:0] DepthX = XW'(DEPTH);

  fsm_e                  state_q, state_d;
  action_e               op_q, op_d;
  logic [ValueWidth-1:0] val_q, val_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CapWidth-1:0]   cap_q;
  logic [CW-1:0]         issue_idx_q, issue_idx_d;
  logic [CW-1:0]         cmp_idx_q, cmp_idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  status_e               res_status_q, res_status_d;
  logic [IndexWidth-1:0] res_idx_q, res_idx_d;
  logic [ValueWidth-1:0] res_pop_q, res_pop_d;

  logic                  out_vld_q, out_vld_d;
  status_e               out_status_q, out_status_d;
  logic [IndexWidth-1:0] out_idx_q, out_idx_d;
  logic [ValueWidth-1:0] out_pop_q, out_pop_d;
  logic [CapWidth-1:0]   out_count_q, out_count_d;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ValueWidth-1:0] mem_wdata, mem_rdata;

  logic [XW-1:0] count_x, cap_x, cap_eff_x;
  logic          full;

  assign count_x   = XW'(count_q);
  assign cap_x     = XW'(cap_q);
  assign cap_eff_x = (cap_x > DepthX) ? DepthX : cap_x;
  assign full      = (count_x >= cap_eff_x);

  uvs_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    count_d      = count_q;
    issue_idx_d  = issue_idx_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = 1'b0;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_pop_d    = res_pop_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_pop_d    = out_pop_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[AW-1:0];
    mem_wdata    = val_q;
    mem_re       = 1'b0;
    mem_raddr    = issue_idx_q[AW-1:0];
    in_i.ready   = 1'b0;

    unique case (state_q)
      FSM_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d         = action_e'(in_i.action);
          val_d        = in_i.item_value;
          res_idx_d    = '0;
          res_pop_d    = '0;
          res_status_d = ST_OK;
          issue_idx_d  = '0;
          state_d      = FSM_DONE;
          unique case (action_e'(in_i.action))
            ACT_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = ST_NOTFOUND;
              end else begin
                state_d = FSM_SCAN;
              end
            end
            ACT_PUSH: begin
              if (full) begin
                res_status_d = ST_OVER;
              end else if (count_q == '0) begin
                // empty stack, nothing to compare against
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_i.item_value;
                count_d   = CW'(1);
              end else begin
                state_d = FSM_SCAN;
              end
            end
            ACT_POP: begin
              if (count_q == '0) begin
                res_status_d = ST_UNDER;
              end else begin
                state_d = FSM_POP_RD;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
              state_d = FSM_DONE;
            end
          endcase
        end
      end

      FSM_SCAN: begin
        // read of entry issue_idx overlaps the compare of entry cmp_idx
        if (issue_idx_q != count_q) begin
          mem_re      = 1'b1;
          issue_idx_d = issue_idx_q + CW'(1);
          cmp_vld_d   = 1'b1;
          cmp_idx_d   = issue_idx_q;
        end
        if (cmp_vld_q) begin
          if (mem_rdata == val_q) begin
            state_d   = FSM_DONE;
            cmp_vld_d = 1'b0;
            if (op_q == ACT_SEARCH) begin
              res_status_d = ST_OK;
              res_idx_d    = IndexWidth'(cmp_idx_q);
            end else begin
              res_status_d = ST_DUP;
            end
          end else if (cmp_idx_q + CW'(1) == count_q) begin
            state_d   = FSM_DONE;
            cmp_vld_d = 1'b0;
            if (op_q == ACT_SEARCH) begin
              res_status_d = ST_NOTFOUND;
            end else begin
              mem_we       = 1'b1;
              count_d      = count_q + CW'(1);
              res_status_d = ST_OK;
            end
          end
        end
      end

      FSM_POP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(count_q - CW'(1));
        count_d   = count_q - CW'(1);
        state_d   = FSM_POP_DATA;
      end

      FSM_POP_DATA: begin
        res_pop_d    = mem_rdata;
        res_status_d = ST_OK;
        state_d      = FSM_DONE;
      end

      FSM_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = res_idx_q;
          out_pop_d    = res_pop_q;
          out_count_d  = CapWidth'(count_q);
          state_d      = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      count_q   <= '0;
      cap_q     <= CapReset;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    issue_idx_q  <= issue_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_pop_q    <= res_pop_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_pop_q    <= out_pop_d;
    out_count_q  <= out_count_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_status_q;
  assign out_o.found_index  = out_idx_q;
  assign out_o.popped_value = out_pop_q;
  assign out_o.entry_count  = out_count_q;

endmodule

FILE: hw/rtl/uvs_mem.sv
module uvs_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [uvs_pkg::ValueWidth-1:0] wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [uvs_pkg::ValueWidth-1:0] rdata_o
);
  import uvs_pkg::*;

  logic [ValueWidth-1:0] mem_q [DEPTH];
  logic [ValueWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: verif/uvs_checker.sv
`timescale 1ns / 1ps

module uvs_checker #(
  parameter int unsigned StackDepth = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [uvs_pkg::CapWidth-1:0] cfg_wdata_i,
  uvs_in_if                            in_mon_i,
  uvs_out_if                           out_mon_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import uvs_pkg::*;

  typedef struct packed {
    status_e               status;
    logic [IndexWidth-1:0] found_index;
    logic [ValueWidth-1:0] popped_value;
    logic [CapWidth-1:0]   entry_count;
  } stack_result_t;

  logic [ValueWidth-1:0] stack_mem [StackDepth];
  int unsigned           depth_used;
  logic [CapWidth-1:0]   capacity_q;
  stack_result_t         expected_results [$];

  // bottom-up scan over the live entries only
  function automatic int lowest_match(input logic [ValueWidth-1:0] val);
    for (int i = 0; i < int'(depth_used); i++) begin
      if (stack_mem[i] == val) return i;
    end
    return -1;
  endfunction

  function automatic stack_result_t apply_action(input action_e act,
                                                 input logic [ValueWidth-1:0] val);
    stack_result_t res;
    int unsigned   limit;
    int            pos;
    res = '0;
    res.status = ST_OK;
    limit = (capacity_q > StackDepth) ? StackDepth : int'(capacity_q);
    case (act)
      ACT_SEARCH: begin
        pos = lowest_match(val);
        if (pos < 0) res.status = ST_NOTFOUND;
        else res.found_index = pos[IndexWidth-1:0];
      end
      ACT_PUSH: begin
        // a full stack gives overflow before any duplicate check
        if (depth_used >= limit) begin
          res.status = ST_OVER;
        end else if (lowest_match(val) >= 0) begin
          res.status = ST_DUP;
        end else begin
          stack_mem[depth_used] = val;
          depth_used++;
        end
      end
      ACT_POP: begin
        if (depth_used == 0) begin
          res.status = ST_UNDER;
        end else begin
          depth_used--;
          res.popped_value = stack_mem[depth_used];
        end
      end
      default: depth_used = 0;
    endcase
    res.entry_count = depth_used[CapWidth-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    stack_result_t want;
    stack_result_t got;
    if (!rst_ni) begin
      depth_used   = 0;
      capacity_q   = CapReset;
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = {status_e'(out_mon_i.status), out_mon_i.found_index,
               out_mon_i.popped_value, out_mon_i.entry_count};
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d count %0d",
                   $time, got.status, got.entry_count);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            fail_count_o++;
          end
          if (got.found_index !== want.found_index) begin
            $display("%0t: found_index expected %0d got %0d", $time,
                     want.found_index, got.found_index);
            fail_count_o++;
          end
          if (got.popped_value !== want.popped_value) begin
            $display("%0t: popped_value expected %h got %h", $time,
                     want.popped_value, got.popped_value);
            fail_count_o++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time,
                     want.entry_count, got.entry_count);
            fail_count_o++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        expected_results.push_back(apply_action(action_e'(in_mon_i.action),
                                                in_mon_i.item_value));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

FILE: verif/tb_unique_value_stack.sv
`timescale 1ns / 1ps

module tb_unique_value_stack;
  import uvs_pkg::*;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned PoolSize   = 12;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CapWidth-1:0]   cfg_wdata_i;
  bit                    calm;
  int unsigned           fail_count;
  int unsigned           pending;
  logic [ValueWidth-1:0] value_pool [PoolSize];

  uvs_in_if  in_ch ();
  uvs_out_if out_ch ();

  unique_value_stack #(
    .DEPTH(StackDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  uvs_checker #(
    .StackDepth(StackDepth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = rst_ni && (calm || ($urandom_range(99) >= 20));
    end
  end

  initial begin
    #60_000_000;
    $display("unique_value_stack test failed");
    $finish;
  end

  // leaves valid high so the next beat can follow without a gap
  task automatic send_beat(input action_e act, input logic [ValueWidth-1:0] val);
    if (!calm && $urandom_range(99) < 20) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.action     = act;
    in_ch.item_value = val;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapWidth-1:0] cap);
    settle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = cap;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic run_phase(input int unsigned items);
    int unsigned           roll;
    action_e               act;
    logic [ValueWidth-1:0] val;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < PoolSize; i++) value_pool[i] = $urandom();
    repeat (items) begin
      roll = $urandom_range(99);
      if (roll < 42) act = ACT_PUSH;
      else if (roll < 72) act = ACT_SEARCH;
      else if (roll < 93) act = ACT_POP;
      else act = ACT_CLEAR;
      // a small pool makes duplicates and search hits common
      if ($urandom_range(99) < 65) val = value_pool[$urandom_range(PoolSize - 1)];
      else val = $urandom();
      if ($urandom_range(199) == 0) settle();
      send_beat(act, val);
    end
  endtask

  initial begin
    logic [ValueWidth-1:0] fill_val;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    calm             = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_SEARCH;
    in_ch.item_value = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty stack, value extremes, duplicate, hits and a miss, clear
    send_beat(ACT_POP, 32'h1234_5678);
    send_beat(ACT_SEARCH, 32'h0000_0000);
    send_beat(ACT_PUSH, 32'h8000_0000);
    send_beat(ACT_PUSH, 32'h7fff_ffff);
    send_beat(ACT_PUSH, 32'h0000_0000);
    send_beat(ACT_PUSH, 32'hffff_ffff);
    send_beat(ACT_PUSH, 32'h7fff_ffff);
    send_beat(ACT_SEARCH, 32'hffff_ffff);
    send_beat(ACT_SEARCH, 32'h8000_0000);
    send_beat(ACT_SEARCH, 32'h0000_0005);
    send_beat(ACT_POP, 32'h0000_0000);
    send_beat(ACT_CLEAR, 32'hffff_ffff);
    send_beat(ACT_POP, 32'h0000_0000);

    // full stack: overflow wins over the duplicate check
    write_capacity(9'd2);
    send_beat(ACT_PUSH, 32'd11);
    send_beat(ACT_PUSH, 32'd22);
    send_beat(ACT_PUSH, 32'd33);
    send_beat(ACT_PUSH, 32'd11);

    // capacity below the count
    write_capacity(9'd1);
    send_beat(ACT_PUSH, 32'd44);
    send_beat(ACT_POP, 32'd0);
    send_beat(ACT_PUSH, 32'd44);
    send_beat(ACT_POP, 32'd0);
    send_beat(ACT_PUSH, 32'd44);

    write_capacity(9'd0);
    send_beat(ACT_PUSH, 32'd55);
    send_beat(ACT_SEARCH, 32'd44);
    send_beat(ACT_CLEAR, 32'd0);

    // capacity above depth saturates: fill every slot
    write_capacity(9'd511);
    for (int i = 0; i < int'(StackDepth); i++) begin
      fill_val        = $urandom();
      fill_val[31:24] = i[7:0];
      send_beat(ACT_PUSH, fill_val);
    end
    send_beat(ACT_PUSH, fill_val);
    send_beat(ACT_PUSH, $urandom());
    send_beat(ACT_SEARCH, fill_val);
    send_beat(ACT_SEARCH, 32'hffff_ffff);
    send_beat(ACT_POP, 32'd0);
    send_beat(ACT_POP, 32'd0);
    send_beat(ACT_SEARCH, fill_val);

    write_capacity(9'd100);
    send_beat(ACT_PUSH, 32'h0bad_cafe);
    run_phase(150);

    write_capacity(CapReset);
    run_phase(300);
    write_capacity(9'd8);
    run_phase(250);
    write_capacity(9'd1);
    run_phase(150);
    write_capacity(9'd0);
    run_phase(60);
    write_capacity(9'd257);
    calm = 1'b1;
    run_phase(300);
    calm = 1'b0;
    write_capacity(9'd511);
    run_phase(300);
    write_capacity(CapWidth'($urandom_range(0, 511)));
    run_phase(200);

    settle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("unique_value_stack test passed");
    end else begin
      $display("unique_value_stack test failed");
    end
    $finish;
  end

endmodule
